// ===== src/generational_slot_allocator_assert.svh =====
// Assertion macros for the generational slot allocator.
// Used by the checker; depends on nothing else.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define GSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define GSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gsa_pkg.sv =====
// Shared types and constants for the generational slot allocator.
// Depends on nothing; used by every module of the block.
package gsa_pkg;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned SLOT_W    = $clog2(CAPACITY);
  localparam int unsigned LINK_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned SLOT_IN_W = 12;
  localparam int unsigned GEN_W     = 32;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned OFFSET_W  = 28;
  localparam int unsigned LIVE_W    = 13;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_LOOKUP  = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_QUERY   = 3'd4
  } gsa_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 3'd0,
    STS_FULL  = 3'd1,
    STS_RANGE = 3'd2,
    STS_FREE  = 3'd3,
    STS_STALE = 3'd4
  } gsa_status_e;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [SLOT_IN_W-1:0] slot_in;
    logic [GEN_W-1:0]     generation_in;
  } gsa_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SLOT_IN_W-1:0] slot_out;
    logic [GEN_W-1:0]     generation_out;
    logic [OFFSET_W-1:0]  item_offset;
    logic                 occupied_out;
    logic [LIVE_W-1:0]    live_count;
  } gsa_rsp_t;

  typedef struct packed {
    logic              occupied;
    logic [GEN_W-1:0]  generation;
    logic [LINK_W-1:0] next_free;
  } gsa_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    gsa_entry_t        wr_data;
  } gsa_mem_req_t;

endpackage

// ===== src/gsa_slot_mem.sv =====
// Slot memory: link, occupied bit and generation per slot, with a registered read.
// Per-entry valid bits make unwritten entries read as their reset value.
// Depends on gsa_pkg.
module gsa_slot_mem import gsa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  gsa_mem_req_t mem_req_i,
  output gsa_entry_t   rd_entry_o
);

  gsa_entry_t          mem_q [CAPACITY];
  gsa_entry_t          rd_data_q;
  logic [SLOT_W-1:0]   rd_addr_q;
  logic [CAPACITY-1:0] vld_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en) begin
      mem_q[mem_req_i.wr_addr] <= mem_req_i.wr_data;
    end
    if (mem_req_i.rd_en) begin
      rd_data_q <= mem_q[mem_req_i.rd_addr];
      rd_addr_q <= mem_req_i.rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_req_i.wr_en) begin
      vld_q[mem_req_i.wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    rd_entry_o = rd_data_q;
    if (!vld_q[rd_addr_q]) begin
      rd_entry_o.occupied   = 1'b0;
      rd_entry_o.generation = '0;
      rd_entry_o.next_free  = LINK_W'(rd_addr_q) + LINK_W'(1);
    end
  end

endmodule

// ===== src/generational_slot_allocator.sv =====
// Generational slot allocator: hands out (slot, generation) handles from a
// fixed pool kept on a free list in one synchronous slot memory. Alloc,
// release, lookup and query each read the slot memory, then check, write
// back and register the response. Clear sweeps the slot memory one entry
// per cycle, its last write waiting for a free output register. One request
// is in flight at a time; a finished response waits in the output register
// while the next request is accepted. No clearing pass follows reset.
module generational_slot_allocator import gsa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [SIZE_W-1:0] cfg_item_size_i,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  gsa_req_t          req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output gsa_rsp_t          rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR
  } state_e;

  state_e                      state_q, state_d;
  gsa_req_t                    req_q;
  logic [LINK_W-1:0]           free_head_q, free_head_d;
  logic [LINK_W-1:0]           used_q, used_d;
  logic [LINK_W-1:0]           cnt_q, cnt_d;
  logic [SIZE_W-1:0]           size_q;
  gsa_rsp_t                    rsp_q, rsp_d;
  logic                        rsp_valid_q, rsp_valid_d;
  gsa_mem_req_t                mem_req;
  gsa_entry_t                  rd_entry;
  logic                        out_free;
  logic                        full;
  logic                        slot_ok;
  logic [SLOT_W-1:0]           slot_idx;
  logic [SLOT_W-1:0]           off_slot;
  logic [SLOT_W+SIZE_W-1:0]    prod;
  logic [OFFSET_W-1:0]         offset;
  logic [GEN_W-1:0]            gen_bump;
  logic [GEN_W-1:0]            gen_alloc;
  logic [SLOT_W-1:0]           clr_addr;

  function automatic logic in_range(input logic [SLOT_IN_W-1:0] s);
    return {1'b0, s} < (SLOT_IN_W + 1)'(CAPACITY);
  endfunction

  function automatic logic [GEN_W-1:0] bump_gen(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = g + GEN_W'(1);
    return (n == '0) ? GEN_W'(1) : n;
  endfunction

  gsa_slot_mem u_slot_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mem_req_i  (mem_req),
    .rd_entry_o (rd_entry)
  );

  assign cfg_ready_o = 1'b1;
  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  assign out_free  = !rsp_valid_q || rsp_ready_i;
  assign full      = (free_head_q == LINK_W'(CAPACITY));
  assign slot_ok   = in_range(req_q.slot_in);
  assign slot_idx  = req_q.slot_in[SLOT_W-1:0];
  assign off_slot  = (req_q.cmd == CMD_ALLOC) ? free_head_q[SLOT_W-1:0] : slot_idx;
  assign prod      = off_slot * size_q;
  assign offset    = OFFSET_W'(prod);
  assign gen_bump  = bump_gen(rd_entry.generation);
  assign gen_alloc = (rd_entry.generation == '0) ? GEN_W'(1) : rd_entry.generation;
  assign clr_addr  = SLOT_W'(cnt_q - LINK_W'(1));

  always_comb begin
    state_d     = state_q;
    free_head_d = free_head_q;
    used_d      = used_q;
    cnt_d       = cnt_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    mem_req     = '0;

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (req_i.cmd == CMD_CLEAR) begin
            state_d = ST_CLEAR;
            cnt_d   = '0;
          end else begin
            state_d = ST_EXEC;
            if (req_i.cmd == CMD_ALLOC) begin
              mem_req.rd_en   = !full;
              mem_req.rd_addr = free_head_q[SLOT_W-1:0];
            end else begin
              mem_req.rd_en   = in_range(req_i.slot_in);
              mem_req.rd_addr = req_i.slot_in[SLOT_W-1:0];
            end
          end
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          state_d        = ST_IDLE;
          rsp_valid_d    = 1'b1;
          rsp_d          = '0;
          rsp_d.status   = STS_OK;
          rsp_d.slot_out = req_q.slot_in;
          case (req_q.cmd)
            CMD_ALLOC: begin
              rsp_d.slot_out = '0;
              if (full) begin
                rsp_d.status = STS_FULL;
              end else begin
                rsp_d.slot_out       = SLOT_IN_W'(free_head_q[SLOT_W-1:0]);
                rsp_d.generation_out = gen_alloc;
                rsp_d.item_offset    = offset;
                rsp_d.occupied_out   = 1'b1;
                free_head_d          = rd_entry.next_free;
                used_d               = used_q + LINK_W'(1);
                mem_req.wr_en        = 1'b1;
                mem_req.wr_addr      = free_head_q[SLOT_W-1:0];
                mem_req.wr_data      = '{occupied: 1'b1, generation: gen_alloc,
                                         next_free: rd_entry.next_free};
              end
            end
            CMD_RELEASE: begin
              if (!slot_ok) begin
                rsp_d.status = STS_RANGE;
              end else begin
                rsp_d.generation_out = rd_entry.generation;
                rsp_d.item_offset    = offset;
                rsp_d.occupied_out   = rd_entry.occupied;
                if (!rd_entry.occupied) begin
                  rsp_d.status = STS_FREE;
                end else if (rd_entry.generation != req_q.generation_in ||
                             req_q.generation_in == '0) begin
                  rsp_d.status = STS_STALE;
                end else begin
                  rsp_d.generation_out = gen_bump;
                  rsp_d.occupied_out   = 1'b0;
                  free_head_d          = LINK_W'(slot_idx);
                  used_d               = used_q - LINK_W'(1);
                  mem_req.wr_en        = 1'b1;
                  mem_req.wr_addr      = slot_idx;
                  mem_req.wr_data      = '{occupied: 1'b0, generation: gen_bump,
                                           next_free: free_head_q};
                end
              end
            end
            CMD_LOOKUP: begin
              if (slot_ok) begin
                rsp_d.generation_out = rd_entry.generation;
                rsp_d.item_offset    = offset;
                rsp_d.occupied_out   = rd_entry.occupied;
              end
              if (req_q.generation_in == '0) begin
                rsp_d.status = STS_STALE;
              end else if (!slot_ok) begin
                rsp_d.status = STS_RANGE;
              end else if (!rd_entry.occupied) begin
                rsp_d.status = STS_FREE;
              end else if (rd_entry.generation != req_q.generation_in) begin
                rsp_d.status = STS_STALE;
              end
            end
            CMD_QUERY: begin
              if (!slot_ok) begin
                rsp_d.status = STS_RANGE;
              end else begin
                rsp_d.generation_out = rd_entry.generation;
                rsp_d.item_offset    = offset;
                rsp_d.occupied_out   = rd_entry.occupied;
              end
            end
            default: begin
              rsp_d.slot_out = '0;
            end
          endcase
          rsp_d.live_count = LIVE_W'(used_d);
        end
      end

      ST_CLEAR: begin
        if (cnt_q != LINK_W'(CAPACITY)) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = cnt_q[SLOT_W-1:0];
          cnt_d           = cnt_q + LINK_W'(1);
          if (cnt_q != '0) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_addr;
            mem_req.wr_data = '{occupied: 1'b0, generation: gen_bump,
                                next_free: LINK_W'(clr_addr) + LINK_W'(1)};
          end
        end else if (out_free) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = clr_addr;
          mem_req.wr_data = '{occupied: 1'b0, generation: gen_bump,
                              next_free: LINK_W'(clr_addr) + LINK_W'(1)};
          free_head_d     = '0;
          used_d          = '0;
          state_d         = ST_IDLE;
          rsp_valid_d     = 1'b1;
          rsp_d           = '0;
          rsp_d.status    = STS_OK;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= '0;
      free_head_q <= '0;
      used_q      <= '0;
      cnt_q       <= '0;
      size_q      <= SIZE_W'(1);
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      used_q      <= used_d;
      cnt_q       <= cnt_d;
      rsp_q       <= rsp_d;
      rsp_valid_q <= rsp_valid_d;
      if (req_valid_i && req_ready_o) begin
        req_q <= req_i;
      end
      if (cfg_valid_i) begin
        size_q <= cfg_item_size_i;
      end
    end
  end

endmodule

// ===== src/gsa_checker.sv =====
// Port-level checks for the generational slot allocator, bound to the top.
// Depends on gsa_pkg and generational_slot_allocator_assert.svh.
`include "generational_slot_allocator_assert.svh"

module gsa_checker import gsa_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_o,
  input logic              rsp_valid_o,
  input logic              rsp_ready_i,
  input gsa_rsp_t          rsp_o
);

  `GSA_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_o && !rsp_ready_i, rsp_valid_o && $stable(rsp_o), "response dropped or changed while stalled")
  `GSA_ASSERT_NXT(a_req_single, clk_i, rst_ni, req_valid_i && req_ready_o, !req_ready_o, "request accepted while one is in flight")
  `GSA_ASSERT_IMP(a_live_bound, clk_i, rst_ni, rsp_valid_o, rsp_o.live_count <= LIVE_W'(CAPACITY), "live count above capacity")
  `GSA_ASSERT_IMP(a_full_count, clk_i, rst_ni, rsp_valid_o && rsp_o.status == STS_FULL, rsp_o.live_count == LIVE_W'(CAPACITY), "full reported with free slots left")
  `GSA_ASSERT_IMP(a_live_gen, clk_i, rst_ni, rsp_valid_o && rsp_o.status == STS_OK && rsp_o.occupied_out, rsp_o.generation_out != '0, "occupied slot with zero generation")

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for generational_slot_allocator: directed handle checks, a full-map
// fill and drain, then random alloc/release/lookup/query/clear traffic under idle/stall mixes.
// Depends on gsa_pkg and the allocator RTL only; predicts every response in-line.
`timescale 1ns / 100ps

module tb_top;
  import gsa_pkg::*;

  localparam int unsigned CMD_LAST       = (1 << CMD_W) - 1;
  localparam int unsigned SLOT_IN_MAX    = (1 << SLOT_IN_W) - 1;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned ERROR_PRINTS   = 50;
  localparam int unsigned BURST_LEN      = 40;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              cfg_valid_i     = 1'b0;
  logic              cfg_ready_o;
  logic [SIZE_W-1:0] cfg_item_size_i = '0;
  logic              req_valid_i     = 1'b0;
  logic              req_ready_o;
  gsa_req_t          req_i           = '0;
  logic              rsp_valid_o;
  logic              rsp_ready_i     = 1'b0;
  gsa_rsp_t          rsp_o;

  logic              map_occupied  [CAPACITY];
  logic [GEN_W-1:0]  map_generation[CAPACITY];
  logic [LINK_W-1:0] map_link      [CAPACITY];
  logic [LINK_W-1:0] map_head;
  logic [LIVE_W-1:0] map_live;
  logic [SIZE_W-1:0] map_item_size;

  gsa_rsp_t rsp_expected_q[$];
  int unsigned send_idle_pct     = 0;
  int unsigned rsp_stall_pct     = 0;
  int unsigned mismatch_count    = 0;
  int unsigned requests_sent     = 0;
  int unsigned responses_checked = 0;
  int unsigned quiet_cycles      = 0;
  logic [SIZE_W-1:0] random_size;

  generational_slot_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_item_size_i(cfg_item_size_i),
    .req_valid_i    (req_valid_i),
    .req_ready_o    (req_ready_o),
    .req_i          (req_i),
    .rsp_valid_o    (rsp_valid_o),
    .rsp_ready_i    (rsp_ready_i),
    .rsp_o          (rsp_o)
  );

  always begin
    #4;
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
  end

  function automatic logic [GEN_W-1:0] next_generation(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = g + 1'b1;
    return (n == '0) ? GEN_W'(1) : n;
  endfunction

  function automatic void rebuild_free_list();
    for (int i = 0; i < CAPACITY; i++) begin
      map_link[i] = LINK_W'(i + 1);
    end
    map_head = '0;
    map_live = '0;
  endfunction

  function automatic gsa_rsp_t slot_view(input int unsigned s);
    gsa_rsp_t o;
    logic [63:0] offset;
    o = '0;
    offset = 64'(s) * 64'(map_item_size);
    o.slot_out       = SLOT_IN_W'(s);
    o.generation_out = map_generation[s];
    o.item_offset    = offset[OFFSET_W-1:0];
    o.occupied_out   = map_occupied[s];
    return o;
  endfunction

  function automatic gsa_rsp_t predict_slot_map(input gsa_req_t r);
    gsa_rsp_t    o;
    gsa_status_e st;
    int unsigned s;
    o  = '0;
    st = STS_OK;
    s  = r.slot_in;
    case (r.cmd)
      CMD_ALLOC: begin
        if (map_head >= CAPACITY) begin
          st = STS_FULL;
        end else begin
          s = map_head;
          map_head = map_link[s];
          map_occupied[s] = 1'b1;
          if (map_generation[s] == '0) map_generation[s] = GEN_W'(1);
          if (map_live < CAPACITY) map_live = map_live + 1'b1;
          o = slot_view(s);
        end
      end
      CMD_RELEASE: begin
        if (s >= CAPACITY) begin
          st = STS_RANGE;
          o.slot_out = r.slot_in;
        end else begin
          if (!map_occupied[s]) begin
            st = STS_FREE;
          end else if (map_generation[s] != r.generation_in || r.generation_in == '0) begin
            st = STS_STALE;
          end else begin
            map_occupied[s] = 1'b0;
            map_link[s] = map_head;
            map_head = LINK_W'(s);
            map_generation[s] = next_generation(map_generation[s]);
            if (map_live > 0) map_live = map_live - 1'b1;
          end
          o = slot_view(s);
        end
      end
      CMD_LOOKUP: begin
        if (r.generation_in == '0) begin
          st = STS_STALE;
          if (s < CAPACITY) o = slot_view(s);
          else o.slot_out = r.slot_in;
        end else if (s >= CAPACITY) begin
          st = STS_RANGE;
          o.slot_out = r.slot_in;
        end else begin
          if (!map_occupied[s]) st = STS_FREE;
          else if (map_generation[s] != r.generation_in) st = STS_STALE;
          o = slot_view(s);
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CAPACITY; i++) begin
          map_occupied[i] = 1'b0;
          map_generation[i] = next_generation(map_generation[i]);
        end
        rebuild_free_list();
      end
      CMD_QUERY: begin
        if (s >= CAPACITY) begin
          st = STS_RANGE;
          o.slot_out = r.slot_in;
        end else begin
          o = slot_view(s);
        end
      end
      default: begin
      end
    endcase
    o.status     = st;
    o.live_count = map_live;
    return o;
  endfunction

  function automatic gsa_req_t make_req(input logic [CMD_W-1:0] cmd, input int unsigned slot,
                                        input logic [GEN_W-1:0] gen);
    gsa_req_t r;
    r.cmd           = cmd;
    r.slot_in       = SLOT_IN_W'(slot);
    r.generation_in = gen;
    return r;
  endfunction

  function automatic int live_slot();
    int live_q[$];
    for (int i = 0; i < CAPACITY; i++) begin
      if (map_occupied[i]) live_q.push_back(i);
    end
    if (live_q.size() == 0) return -1;
    return live_q[$urandom_range(live_q.size() - 1, 0)];
  endfunction

  task automatic flag_error(input string msg);
    if (mismatch_count < ERROR_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) flag_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  task automatic send_request(input gsa_req_t r);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    do @(posedge clk_i); while (!req_ready_o);
    rsp_expected_q.push_back(predict_slot_map(r));
    requests_sent++;
  endtask

  task automatic wait_drained();
    if (req_valid_i) req_valid_i <= 1'b0;
    while (rsp_expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_item_size(input logic [SIZE_W-1:0] size);
    wait_drained();
    cfg_valid_i     <= 1'b1;
    cfg_item_size_i <= size;
    do @(posedge clk_i); while (!cfg_ready_o);
    map_item_size = size;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_handle_checks();
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    write_item_size(SIZE_W'(3));
    send_request(make_req(CMD_ALLOC, $urandom_range(SLOT_IN_MAX, 0), $urandom()));
    send_request(make_req(CMD_ALLOC, $urandom_range(SLOT_IN_MAX, 0), $urandom()));
    send_request(make_req(CMD_QUERY, 0, $urandom()));
    send_request(make_req(CMD_LOOKUP, 0, map_generation[0]));
    send_request(make_req(CMD_LOOKUP, 0, '0));
    send_request(make_req(CMD_LOOKUP, 0, '1));
    send_request(make_req(CMD_LOOKUP, SLOT_IN_MAX, GEN_W'(1)));
    send_request(make_req(CMD_LOOKUP, SLOT_IN_MAX, '0));
    send_request(make_req(CMD_LOOKUP, 5, GEN_W'(1)));
    send_request(make_req(CMD_RELEASE, SLOT_IN_MAX, GEN_W'(1)));
    send_request(make_req(CMD_RELEASE, 5, GEN_W'(1)));
    send_request(make_req(CMD_RELEASE, 0, '0));
    send_request(make_req(CMD_RELEASE, 0, map_generation[0] + 1'b1));
    send_request(make_req(CMD_RELEASE, 0, map_generation[0]));
    send_request(make_req(CMD_LOOKUP, 0, map_generation[0] - 1'b1));
    send_request(make_req(CMD_QUERY, 0, '1));
    send_request(make_req(CMD_QUERY, SLOT_IN_MAX, '0));
    send_request(make_req(CMD_QUERY, CAPACITY, $urandom()));
    send_request(make_req(CMD_QUERY, CAPACITY - 1, $urandom()));
    for (int c = CMD_QUERY + 1; c <= CMD_LAST; c++) begin
      send_request(make_req(CMD_W'(c), $urandom_range(SLOT_IN_MAX, 0), $urandom()));
    end
    // hold off until every response is back, then clear
    wait_drained();
    send_request(make_req(CMD_CLEAR, $urandom_range(SLOT_IN_MAX, 0), $urandom()));
    send_request(make_req(CMD_ALLOC, 0, '0));
    send_request(make_req(CMD_LOOKUP, 1, map_generation[1] - 1'b1));
  endtask

  task automatic test_full_map();
    int order[$];
    int j;
    int tmp;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    write_item_size('1);
    repeat (CAPACITY + 2) begin
      send_request(make_req(CMD_ALLOC, $urandom_range(SLOT_IN_MAX, 0), $urandom()));
    end
    for (int i = 0; i < CAPACITY; i++) order.push_back(i);
    for (int i = CAPACITY - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) begin
      send_request(make_req(CMD_RELEASE, order[i], map_generation[order[i]]));
      if ($urandom_range(3, 0) == 0) begin
        send_request(make_req(CMD_QUERY, order[i], $urandom()));
      end
    end
  endtask

  task automatic test_traffic(input int unsigned send_pct, input int unsigned stall_pct,
                              input logic [SIZE_W-1:0] size, input int count);
    int               s;
    int unsigned      pick;
    int unsigned      alloc_pct;
    logic [GEN_W-1:0] g;
    logic [CMD_W-1:0] cmd;
    write_item_size(size);
    send_idle_pct = send_pct;
    rsp_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      // alternate fill-heavy and drain-heavy bursts
      alloc_pct = ((n / BURST_LEN) % 2 == 0) ? 80 : 15;
      if ($urandom_range(99, 0) < 3) wait_drained();
      s = live_slot();
      pick = $urandom_range(99, 0);
      if (pick < alloc_pct) begin
        send_request(make_req(CMD_ALLOC, $urandom_range(SLOT_IN_MAX, 0), $urandom()));
      end else begin
        pick = $urandom_range(99, 0);
        if (pick < 45 && s >= 0) begin
          send_request(make_req(CMD_RELEASE, s, map_generation[s]));
        end else if (pick < 60 && s >= 0) begin
          send_request(make_req(CMD_LOOKUP, s, map_generation[s]));
        end else if (pick < 70) begin
          send_request(make_req(CMD_QUERY, $urandom_range(CAPACITY - 1, 0), $urandom()));
        end else if (pick < 72) begin
          send_request(make_req(CMD_CLEAR, $urandom_range(SLOT_IN_MAX, 0), $urandom()));
        end else if (pick < 88) begin
          s = $urandom_range(CAPACITY - 1, 0);
          case ($urandom_range(2, 0))
            0:       g = '0;
            1:       g = map_generation[s] + 1'b1;
            default: g = $urandom();
          endcase
          cmd = ($urandom_range(1, 0) == 0) ? CMD_RELEASE : CMD_LOOKUP;
          send_request(make_req(cmd, s, g));
        end else if (pick < 96) begin
          case ($urandom_range(2, 0))
            0:       cmd = CMD_RELEASE;
            1:       cmd = CMD_LOOKUP;
            default: cmd = CMD_QUERY;
          endcase
          send_request(make_req(cmd, $urandom_range(SLOT_IN_MAX, CAPACITY), $urandom()));
        end else begin
          send_request(make_req(CMD_W'($urandom_range(CMD_LAST, CMD_QUERY + 1)),
                                $urandom_range(SLOT_IN_MAX, 0), $urandom()));
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    rsp_ready_i <= ($urandom_range(99, 0) >= rsp_stall_pct);
  end

  always @(posedge clk_i) begin : check_rsp
    gsa_rsp_t want;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (rsp_expected_q.size() == 0) begin
        flag_error($sformatf("response 0x%0h with no request outstanding", rsp_o));
      end else begin
        want = rsp_expected_q.pop_front();
        check_field("status", rsp_o.status, want.status);
        check_field("slot_out", rsp_o.slot_out, want.slot_out);
        check_field("generation_out", rsp_o.generation_out, want.generation_out);
        check_field("item_offset", rsp_o.item_offset, want.item_offset);
        check_field("occupied_out", rsp_o.occupied_out, want.occupied_out);
        check_field("live_count", rsp_o.live_count, want.live_count);
        responses_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no handshake for %0d cycles", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      map_occupied[i]   = 1'b0;
      map_generation[i] = '0;
    end
    rebuild_free_list();
    map_item_size = SIZE_W'(1);
    random_size   = SIZE_W'($urandom_range((1 << SIZE_W) - 1, 1));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_handle_checks();
    test_full_map();
    test_traffic(0, 0, '0, 140);
    test_traffic(47, 0, SIZE_W'(1), 140);
    test_traffic(0, 47, random_size, 140);
    test_traffic(25, 25, '1, 140);

    wait_drained();
    repeat (CAPACITY + 4) @(posedge clk_i);
    if (rsp_expected_q.size() != 0) begin
      flag_error($sformatf("%0d responses never arrived", rsp_expected_q.size()));
    end
    $display("Checked %0d responses for %0d requests: handle checks, full-map fill and drain,",
             responses_checked, requests_sent);
    $display("random traffic under four idle/stall mixes, item sizes 0, 1, 3, %0d and 65535.",
             random_size);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
